// ----- design/irkd_pkg.sv -----
// Shared types and constants for the infrared pulse key decoder.
`timescale 1ns / 1ps
`default_nettype none
package irkd_pkg;

  localparam int TableDepth = 16;
  localparam int MaxSymbols = 64;
  localparam int CodeBits   = 32;
  localparam int RepeatMin  = 2;

  localparam int IdxW  = $clog2(TableDepth);
  localparam int LimW  = $clog2(TableDepth + 1);
  localparam int CntW  = $clog2(MaxSymbols + 1);
  localparam int BitsW = $clog2(CodeBits + 1);

  localparam logic [1:0] KindSymbol = 2'd0;
  localparam logic [1:0] KindTick   = 2'd1;
  localparam logic [1:0] KindWrite  = 2'd2;

  localparam logic [1:0] CfgTableSize    = 2'd0;
  localparam logic [1:0] CfgOneThreshold = 2'd1;
  localparam logic [1:0] CfgMinSymbols   = 2'd2;
  localparam logic [1:0] CfgDebounceMs   = 2'd3;

  localparam logic [2:0] StatusAccepted  = 3'd0;
  localparam logic [2:0] StatusDuplicate = 3'd1;
  localparam logic [2:0] StatusUnknown   = 3'd2;
  localparam logic [2:0] StatusRepeat    = 3'd3;
  localparam logic [2:0] StatusIgnored   = 3'd4;

  typedef enum logic [1:0] {
    StIdle,
    StSearch,
    StDeliver
  } irkd_state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [14:0] duration;
    logic        last;
    logic [3:0]  entry_index;
    logic [31:0] entry_code;
    logic [7:0]  entry_key;
  } irkd_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  key_id;
    logic [31:0] frame_code;
    logic [3:0]  match_index;
  } irkd_out_t;

  typedef struct packed {
    logic            valid;
    logic            found;
    logic [31:0]     code;
    logic [IdxW-1:0] idx;
    logic [7:0]      key;
  } irkd_probe_t;

endpackage
`default_nettype wire

// ----- design/irkd_cell.sv -----
// One key table slot that compares a passing probe against its stored code.
`timescale 1ns / 1ps
`default_nettype none
module irkd_cell (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [irkd_pkg::IdxW-1:0]   slot_i,
  input  wire logic [irkd_pkg::LimW-1:0]   lim_i,
  input  wire logic                        wr_en_i,
  input  wire logic [31:0]                 wr_code_i,
  input  wire logic [7:0]                  wr_key_i,
  input  wire irkd_pkg::irkd_probe_t       probe_i,
  output      irkd_pkg::irkd_probe_t       probe_o
);
  import irkd_pkg::*;

  logic [31:0] code_q;
  logic [7:0]  key_q;
  logic        valid_q;
  irkd_probe_t probe_q;
  irkd_probe_t probe_d;
  logic        active;

  assign active = LimW'(slot_i) < lim_i;

  always_comb begin
    probe_d = probe_i;
    if (!probe_i.found && active && (code_q == probe_i.code)) begin
      probe_d.found = 1'b1;
      probe_d.idx   = slot_i;
      probe_d.key   = key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      code_q <= wr_code_i;
      key_q  <= wr_key_i;
    end
    probe_q <= probe_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= probe_i.valid;
    end
  end

  always_comb begin
    probe_o       = probe_q;
    probe_o.valid = valid_q;
  end

endmodule
`default_nettype wire

// ----- design/irkd_chain.sv -----
// Row of key table cells through which a lookup probe advances one slot per cycle.
`timescale 1ns / 1ps
`default_nettype none
module irkd_chain (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [irkd_pkg::LimW-1:0]   lim_i,
  input  wire logic                        wr_en_i,
  input  wire logic [3:0]                  wr_slot_i,
  input  wire logic [31:0]                 wr_code_i,
  input  wire logic [7:0]                  wr_key_i,
  input  wire irkd_pkg::irkd_probe_t       probe_i,
  output      irkd_pkg::irkd_probe_t       probe_o
);
  import irkd_pkg::*;

  irkd_probe_t probe_w [TableDepth+1];

  assign probe_w[0] = probe_i;
  assign probe_o    = probe_w[TableDepth];

  for (genvar g = 0; g < TableDepth; g++) begin : g_cell
    logic sel;
    assign sel = wr_en_i && ({24'd0, wr_slot_i} == 28'(g));

    irkd_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .slot_i    (IdxW'(g)),
      .lim_i     (lim_i),
      .wr_en_i   (sel),
      .wr_code_i (wr_code_i),
      .wr_key_i  (wr_key_i),
      .probe_i   (probe_w[g]),
      .probe_o   (probe_w[g+1])
    );
  end

endmodule
`default_nettype wire

// ----- design/ir_pulse_key_decoder.sv -----
// Top level of the infrared pulse key decoder: frame assembly, lookup control, debounce.
// A symbol that closes a frame and passes the length and zero-code checks starts a lookup
// that walks the row of table cells one slot per cycle, and no further item is taken until
// its result has been loaded into the output register; short and repeat frames give their
// result without a lookup. Items that produce no result are taken while a result waits.
`timescale 1ns / 1ps
`default_nettype none
module ir_pulse_key_decoder (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire irkd_pkg::irkd_in_t    in_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      irkd_pkg::irkd_out_t   out_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [1:0]            cfg_idx_i,
  input  wire logic [15:0]           cfg_data_i
);
  import irkd_pkg::*;

  irkd_state_e state_q, state_d;

  logic [4:0]      table_size_q;
  logic [14:0]     one_threshold_q;
  logic [6:0]      min_symbols_q;
  logic [15:0]     debounce_ms_q;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [31:0]     shift_q, shift_d;
  logic [7:0]      prev_key_q, prev_key_d;
  logic            prev_valid_q, prev_valid_d;
  logic [15:0]     since_q, since_d;

  logic            out_valid_q, out_valid_d;
  irkd_out_t       out_q, out_d;
  irkd_probe_t     hold_q;

  irkd_probe_t     launch_probe;
  irkd_probe_t     chain_out;
  logic [LimW-1:0] lim;

  logic            closes, out_free, in_fire;
  logic            launch, deliver, short_done, capture;
  logic [CntW-1:0] cnt_step, nm1;
  logic [31:0]     shift_step, code;
  logic [BitsW-1:0] nbits;
  logic            short_frame;
  logic            table_wr;

  assign closes   = (in_i.kind == KindSymbol) && in_i.last;
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle) && (out_free || !closes);
  assign in_fire  = in_valid_i && in_ready_o;
  assign table_wr = in_fire && (in_i.kind == KindWrite) &&
                    ({28'd0, in_i.entry_index} < 32'(TableDepth));

  assign lim = ({27'd0, table_size_q} > 32'(TableDepth)) ? LimW'(TableDepth)
                                                         : LimW'(table_size_q);

  // Symbol accumulation and frame code extraction
  always_comb begin
    cnt_step   = cnt_q;
    shift_step = shift_q;
    if (cnt_q < CntW'(MaxSymbols)) begin
      cnt_step = cnt_q + CntW'(1);
      if ((cnt_q >= CntW'(1)) && (cnt_q <= CntW'(CodeBits))) begin
        shift_step = {in_i.duration > one_threshold_q, shift_q[31:1]};
      end
    end
    nm1 = (cnt_step == '0) ? '0 : cnt_step - CntW'(1);
    nbits = (nm1 > CntW'(CodeBits)) ? BitsW'(CodeBits) : BitsW'(nm1);
    if (nbits == '0) begin
      code = '0;
    end else begin
      code = shift_step >> (BitsW'(CodeBits) - nbits);
    end
    short_frame = ({{(8 - CntW){1'b0}}, cnt_step} < {1'b0, min_symbols_q}) ||
                  (code == '0);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire && closes && !short_frame) state_d = StSearch;
      end
      StSearch: begin
        if (chain_out.valid) state_d = StDeliver;
      end
      StDeliver: begin
        if (out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Control outputs
  always_comb begin
    launch     = 1'b0;
    short_done = 1'b0;
    capture    = 1'b0;
    deliver    = 1'b0;
    unique case (state_q)
      StIdle: begin
        launch     = in_fire && closes && !short_frame;
        short_done = in_fire && closes && short_frame;
      end
      StSearch: capture = chain_out.valid;
      StDeliver: deliver = out_free;
      default: ;
    endcase
  end

  always_comb begin
    launch_probe       = '0;
    launch_probe.valid = launch;
    launch_probe.code  = code;
  end

  irkd_chain u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .lim_i     (lim),
    .wr_en_i   (table_wr),
    .wr_slot_i (in_i.entry_index),
    .wr_code_i (in_i.entry_code),
    .wr_key_i  (in_i.entry_key),
    .probe_i   (launch_probe),
    .probe_o   (chain_out)
  );

  // Datapath next values
  always_comb begin
    cnt_d        = cnt_q;
    shift_d      = shift_q;
    prev_key_d   = prev_key_q;
    prev_valid_d = prev_valid_q;
    since_d      = since_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;

    if (in_fire && (in_i.kind == KindSymbol)) begin
      cnt_d   = cnt_step;
      shift_d = shift_step;
      if (in_i.last) begin
        cnt_d   = '0;
        shift_d = '0;
      end
    end
    if (in_fire && (in_i.kind == KindTick) && (since_q != 16'hFFFF)) begin
      since_d = since_q + 16'd1;
    end

    if (short_done) begin
      out_valid_d        = 1'b1;
      out_d.status       = (cnt_step > CntW'(RepeatMin)) ? StatusRepeat : StatusIgnored;
      out_d.key_id       = '0;
      out_d.frame_code   = '0;
      out_d.match_index  = '0;
    end

    if (deliver) begin
      out_valid_d      = 1'b1;
      out_d.frame_code = hold_q.code;
      if (!hold_q.found) begin
        out_d.status      = StatusUnknown;
        out_d.key_id      = '0;
        out_d.match_index = '0;
      end else begin
        out_d.key_id      = hold_q.key;
        out_d.match_index = 4'(hold_q.idx);
        if (prev_valid_q && (prev_key_q == hold_q.key) && (since_q < debounce_ms_q)) begin
          out_d.status = StatusDuplicate;
        end else begin
          out_d.status = StatusAccepted;
          prev_key_d   = hold_q.key;
          prev_valid_d = 1'b1;
          since_d      = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture) hold_q <= chain_out;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= StIdle;
      table_size_q    <= 5'd0;
      one_threshold_q <= 15'd1100;
      min_symbols_q   <= 7'd34;
      debounce_ms_q   <= 16'd200;
      cnt_q           <= '0;
      shift_q         <= '0;
      prev_key_q      <= '0;
      prev_valid_q    <= 1'b0;
      since_q         <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      shift_q      <= shift_d;
      prev_key_q   <= prev_key_d;
      prev_valid_q <= prev_valid_d;
      since_q      <= since_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgTableSize:    table_size_q    <= cfg_data_i[4:0];
          CfgOneThreshold: one_threshold_q <= cfg_data_i[14:0];
          CfgMinSymbols:   min_symbols_q   <= cfg_data_i[6:0];
          CfgDebounceMs:   debounce_ms_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
`default_nettype wire
